/* hw/rtl/per_port_saturating_counters_macros.svh */
// assertion macros for the counter table rtl
// no dependencies; included by ppsc_back, which carries the assertions
`ifndef PER_PORT_SATURATING_COUNTERS_MACROS_SVH
`define PER_PORT_SATURATING_COUNTERS_MACROS_SVH

// plain property, checked on every edge outside reset
`define PPSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication, checked outside reset
`define PPSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/ppsc_pkg.sv */
// shared types and constants for the per-port saturating counter table
// no dependencies
`default_nettype none

package ppsc_pkg;

  // default sizing
  localparam int PORTS_DEF       = 65536;
  localparam int KINDS_DEF       = 4;
  localparam int COUNT_WIDTH_DEF = 32;

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int KIND_W   = 2;
  localparam int PORT_W   = 16;
  localparam int OUT_W    = 32;

  // item queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NEW   = 2'd0,
    ACT_EXIST = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                table_select;
    logic [KIND_W-1:0]   proto_kind;
    logic [PORT_W-1:0]   port_number;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] count_value;
    logic             has_count;
  } out_item_t;

  // classified item as held in the queue
  typedef struct packed {
    action_t           action;
    logic              in_range;
    logic              table_select;
    logic [KIND_W-1:0] proto_kind;
    logic [PORT_W-1:0] port_number;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    B_CLEAR = 2'd0,
    B_IDLE  = 2'd1,
    B_EXEC  = 2'd2
  } back_state_t;

endpackage

`default_nettype wire

/* hw/rtl/per_port_saturating_counters.sv */
// top level of the per-port saturating counter table
// depends on ppsc_pkg, ppsc_front, ppsc_queue and ppsc_back
`default_nettype none

// Two tables of saturating counters, new connections and all connections,
// each indexed by protocol kind and a 16-bit port or protocol number.
// Input: an item (action, table_select, proto_kind, port_number) is taken
// on a clock edge with start high and busy low. In-range count items bump one or
// both tables, a read item returns one result, a clear item zeroes both.
// Output: a read result is driven on out_item, with out_strobe high for a
// single cycle; the receiver cannot stall, so nothing waits on it.
// Path: a taken item waits in the queue, is popped in the idle state with its
// counters read into registers, and is modified and written back in the exec
// state, where a read result is loaded into the output register; items queued
// ahead are handled first. The back end finishes each item before it pops the
// next; a two-entry queue lets start arrive back to back for short bursts.
// Clear: both tables are swept one entry per cycle over all 2**(row bits +
// column bits) entries, 262144 with the default sizing, with busy held high.
// Reset: rst_n low starts the same sweep, so busy stays high after reset until
// the sweep ends and the first item can be taken.
module per_port_saturating_counters #(
  parameter int PORTS       = ppsc_pkg::PORTS_DEF,
  parameter int KINDS       = ppsc_pkg::KINDS_DEF,
  parameter int COUNT_WIDTH = ppsc_pkg::COUNT_WIDTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  ppsc_pkg::in_item_t   in_item,
  output logic                 out_strobe,
  output ppsc_pkg::out_item_t  out_item
);
  import ppsc_pkg::*;

  logic       push, pop, clearing;
  qent_t      push_ent, head;
  q_status_t  q_stat;

  // decode and admission
  ppsc_front #(
    .PORTS (PORTS),
    .KINDS (KINDS)
  ) u_front (
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .clearing (clearing),
    .push     (push),
    .push_ent (push_ent)
  );

  // decoupling queue
  ppsc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // counter tables and sequencer
  ppsc_back #(
    .PORTS       (PORTS),
    .KINDS       (KINDS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .clearing   (clearing),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

/* hw/rtl/ppsc_front.sv */
// front end: accepts items, decodes the action and checks the index range
// depends on ppsc_pkg
`default_nettype none

module ppsc_front #(
  parameter int PORTS = ppsc_pkg::PORTS_DEF,
  parameter int KINDS = ppsc_pkg::KINDS_DEF
) (
  input  wire                   start,
  output logic                  busy,
  input  ppsc_pkg::in_item_t    in_item,
  input  ppsc_pkg::q_status_t   q_stat,
  input  wire                   clearing,
  output logic                  push,
  output ppsc_pkg::qent_t       push_ent
);
  import ppsc_pkg::*;

  // hold off while the queue is full or the tables are being swept
  assign busy = q_stat.full || clearing;
  assign push = start && !busy;

  // classify the item
  always_comb begin
    push_ent.action       = action_t'(in_item.action);
    push_ent.in_range     = (32'(in_item.proto_kind) < KINDS) &&
                            (32'(in_item.port_number) < PORTS);
    push_ent.table_select = in_item.table_select;
    push_ent.proto_kind   = in_item.proto_kind;
    push_ent.port_number  = in_item.port_number;
  end

endmodule

`default_nettype wire

/* hw/rtl/ppsc_queue.sv */
// short fifo of classified items between front and back
// depends on ppsc_pkg
`default_nettype none

module ppsc_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  ppsc_pkg::qent_t      push_ent,
  input  wire                  pop,
  output ppsc_pkg::qent_t      head,
  output ppsc_pkg::q_status_t  q_stat
);
  import ppsc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qent_t             ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // pointer advance with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

  assign head         = ent_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

endmodule

`default_nettype wire

/* hw/rtl/ppsc_back.sv */
// back end: counter memories, read-modify-write sequencer and clear sweep
// depends on ppsc_pkg and the assertion macro header
`default_nettype none
`include "per_port_saturating_counters_macros.svh"

module ppsc_back #(
  parameter int PORTS       = ppsc_pkg::PORTS_DEF,
  parameter int KINDS       = ppsc_pkg::KINDS_DEF,
  parameter int COUNT_WIDTH = ppsc_pkg::COUNT_WIDTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ppsc_pkg::qent_t      head,
  input  ppsc_pkg::q_status_t  q_stat,
  output logic                 pop,
  output logic                 clearing,
  output logic                 out_strobe,
  output ppsc_pkg::out_item_t  out_item
);
  import ppsc_pkg::*;

  localparam int ROW_W  = (KINDS > 1) ? $clog2(KINDS) : 1;
  localparam int COL_W  = $clog2(PORTS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;

  back_state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]       clr_cnt_r, clr_cnt_nxt;
  qent_t                   cur_r;
  logic [COUNT_WIDTH-1:0]  rd_new_r, rd_all_r;
  logic                    out_strobe_r;
  out_item_t               out_item_r;

  logic [COUNT_WIDTH-1:0]  new_mem [DEPTH];
  logic [COUNT_WIDTH-1:0]  all_mem [DEPTH];

  logic [ADDR_W-1:0]       rd_addr, cur_addr, wr_addr;
  logic                    we_new, we_all, out_load;
  logic [COUNT_WIDTH-1:0]  wdata_new, wdata_all, sat_new, sat_all, rd_sel;

  // row is protocol kind, column is port number
  assign rd_addr  = {ROW_W'(head.proto_kind), COL_W'(head.port_number)};
  assign cur_addr = {ROW_W'(cur_r.proto_kind), COL_W'(cur_r.port_number)};

  // saturating increments of the fetched counters
  assign sat_new = (rd_new_r == '1) ? rd_new_r : rd_new_r + COUNT_WIDTH'(1);
  assign sat_all = (rd_all_r == '1) ? rd_all_r : rd_all_r + COUNT_WIDTH'(1);

  // selected counter for a read, zero when the index is out of range
  assign rd_sel = !cur_r.in_range ? '0 : (cur_r.table_select ? rd_all_r : rd_new_r);

  // next state
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      B_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_stat.empty) begin
          if (head.action == ACT_CLEAR) begin
            state_nxt   = B_CLEAR;
            clr_cnt_nxt = '0;
          end else begin
            state_nxt = B_EXEC;
          end
        end
      end
      B_EXEC: begin
        state_nxt = B_IDLE;
      end
      default: begin
        state_nxt = B_CLEAR;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop       = 1'b0;
    we_new    = 1'b0;
    we_all    = 1'b0;
    out_load  = 1'b0;
    wr_addr   = cur_addr;
    wdata_new = sat_new;
    wdata_all = sat_all;
    unique case (state_r)
      B_CLEAR: begin
        we_new    = 1'b1;
        we_all    = 1'b1;
        wr_addr   = clr_cnt_r;
        wdata_new = '0;
        wdata_all = '0;
      end
      B_IDLE: begin
        pop = !q_stat.empty;
      end
      B_EXEC: begin
        unique case (cur_r.action)
          ACT_NEW: begin
            we_new = cur_r.in_range;
            we_all = cur_r.in_range;
          end
          ACT_EXIST: begin
            we_all = cur_r.in_range;
          end
          ACT_READ: begin
            out_load = 1'b1;
          end
          ACT_CLEAR: begin
            out_load = 1'b0;
          end
        endcase
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_CLEAR;
      clr_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_strobe_r <= out_load;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (out_load) begin
      out_item_r.count_value <= OUT_W'(rd_sel);
      out_item_r.has_count   <= |rd_sel;
    end
  end

  // new-connection counters
  always_ff @(posedge clk) begin
    if (we_new) begin
      new_mem[wr_addr] <= wdata_new;
    end
    if (pop) begin
      rd_new_r <= new_mem[rd_addr];
    end
  end

  // all-connection counters
  always_ff @(posedge clk) begin
    if (we_all) begin
      all_mem[wr_addr] <= wdata_all;
    end
    if (pop) begin
      rd_all_r <= all_mem[rd_addr];
    end
  end

  assign clearing   = (state_r == B_CLEAR);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // checks
  `PPSC_ASSERT_IMPL(a_pop_when_idle, clk, rst_n, pop, (state_r == B_IDLE) && !q_stat.empty, "pop outside idle or from empty queue")
  `PPSC_ASSERT_IMPL(a_strobe_after_read, clk, rst_n, out_strobe_r, $past((state_r == B_EXEC) && (cur_r.action == ACT_READ)), "result without a read")
  `PPSC_ASSERT_IMPL(a_range_zero, clk, rst_n, out_strobe_r && $past(!cur_r.in_range), !out_item_r.has_count && (out_item_r.count_value == '0), "out of range read not zero")
  `PPSC_ASSERT_IMPL(a_write_guard, clk, rst_n, we_new || we_all, (state_r == B_CLEAR) || cur_r.in_range, "counter write with out of range index")

endmodule

`default_nettype wire
